// ===== hw/rtl/infix_to_postfix_converter_top_assert.svh =====
// Assertion macros for the infix-to-postfix converter.
// Included by the top level; no other dependencies.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset
`define I2P_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never hold outside reset
`define I2P_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define I2P_ASSERT(lbl, clk, rstn, prop, msg)
`define I2P_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== hw/rtl/i2p_pkg.sv =====
// Shared types, character codes and the precedence function of the converter.
// No dependencies.
package i2p_pkg;

  // Request kinds
  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // ASCII codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // Item class decided by the front end
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_LETTER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_FLUSH
  } i2p_cls_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PUSH,
    ST_FIN
  } i2p_state_e;

  typedef logic [1:0] prec_t;

  // Classified item passed through the queue
  typedef struct packed {
    i2p_cls_e    cls;
    logic [7:0]  chr;
    prec_t       prec;
  } i2p_item_t;

  // Operator precedence; zero for anything that is not an operator
  function automatic prec_t prec_of(logic [7:0] c);
    prec_t p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

endpackage

// ===== hw/rtl/i2p_front.sv =====
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on i2p_pkg.
module i2p_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [7:0]          in_char_i,
  output logic                q_valid_o,
  output i2p_pkg::i2p_item_t  q_item_o,
  input  logic                q_pop_i
);

  localparam int unsigned QD = 2;

  i2p_pkg::i2p_item_t q_mem [QD];
  logic               wp_q, wp_d, rp_q, rp_d;
  logic [1:0]         qcnt_q, qcnt_d;
  i2p_pkg::i2p_item_t item;
  logic               is_letter;
  logic               push, pop;

  // Classify the incoming character
  assign is_letter = (in_char_i >= i2p_pkg::CH_LO_A && in_char_i <= i2p_pkg::CH_LO_Z) ||
                     (in_char_i >= i2p_pkg::CH_UP_A && in_char_i <= i2p_pkg::CH_UP_Z);

  always_comb begin
    item.chr  = in_char_i;
    item.prec = i2p_pkg::prec_of(in_char_i);
    if (req_type_i == i2p_pkg::REQ_FLUSH) begin
      item.cls = i2p_pkg::CLS_FLUSH;
    end else if (is_letter) begin
      item.cls = i2p_pkg::CLS_LETTER;
    end else if (in_char_i == i2p_pkg::CH_LPAREN) begin
      item.cls = i2p_pkg::CLS_OPEN;
    end else if (in_char_i == i2p_pkg::CH_RPAREN) begin
      item.cls = i2p_pkg::CLS_CLOSE;
    end else if (item.prec != 2'd0) begin
      item.cls = i2p_pkg::CLS_OPER;
    end else begin
      item.cls = i2p_pkg::CLS_NONE;
    end
  end

  // Queue control; ignored characters are accepted but not queued
  assign in_stall_o = (qcnt_q == 2'(QD));
  assign push       = in_valid_i && !in_stall_o && (item.cls != i2p_pkg::CLS_NONE);
  assign pop        = q_pop_i && (qcnt_q != 2'd0);
  assign q_valid_o  = (qcnt_q != 2'd0);
  assign q_item_o   = q_mem[rp_q];

  always_comb begin
    wp_d   = push ? wp_q + 1'b1 : wp_q;
    rp_d   = pop  ? rp_q + 1'b1 : rp_q;
    qcnt_d = qcnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      qcnt_q <= 2'd0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      qcnt_q <= qcnt_d;
    end
  end

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= item;
    end
  end

endmodule

// ===== hw/rtl/i2p_back.sv =====
// Back end: operator stack sequencer, result lookahead and output register.
// Depends on i2p_pkg.
module i2p_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  i2p_pkg::i2p_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_char_o,
  output logic                out_last_o,
  output logic                error_flag_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  i2p_pkg::i2p_state_e state_q, state_d;
  i2p_pkg::i2p_item_t  cur_q, cur_d;
  logic [CW-1:0]       cnt_q, cnt_d, cnt_m1;
  logic                err_q, err_d;
  logic                pend_v_q, pend_v_d;
  logic [7:0]          pend_c_q, pend_c_d;
  logic                out_v_q, out_v_d;
  logic [7:0]          out_c_q;
  logic                out_l_q, out_e_q;

  // Stack memory with registered read
  logic [7:0]          mem [STACK_DEPTH];
  logic [7:0]          rd_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       raddr, waddr;

  // Result request toward the output register
  logic                emit;
  logic [7:0]          emit_c;
  logic                emit_l, emit_e;

  logic                out_ok, stk_empty, stk_full;
  logic                top_open, top_low, ev_emit, ev_go, fin_has, fin_go;

  assign out_ok    = !out_v_q || !out_stall_i;
  assign stk_empty = (cnt_q == '0);
  assign stk_full  = (cnt_q == CW'(STACK_DEPTH));
  assign cnt_m1    = cnt_q - CW'(1);
  assign raddr     = cnt_m1[AW-1:0];
  assign waddr     = cnt_q[AW-1:0];

  // Top-of-stack decisions
  assign top_open = (rd_q == i2p_pkg::CH_LPAREN);
  assign top_low  = (i2p_pkg::prec_of(rd_q) < cur_q.prec);
  assign ev_emit  = !top_open && !(cur_q.cls == i2p_pkg::CLS_OPER && top_low);
  assign ev_go    = !ev_emit || !pend_v_q || out_ok;
  assign fin_has  = pend_v_q || err_q;
  assign fin_go   = !fin_has || out_ok;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2p_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.cls == i2p_pkg::CLS_LETTER || q_item_i.cls == i2p_pkg::CLS_NONE) begin
            state_d = i2p_pkg::ST_FIN;
          end else if (q_item_i.cls == i2p_pkg::CLS_OPEN) begin
            state_d = i2p_pkg::ST_PUSH;
          end else begin
            state_d = i2p_pkg::ST_READ;
          end
        end
      end
      i2p_pkg::ST_READ: begin
        if (!stk_empty) begin
          state_d = i2p_pkg::ST_EVAL;
        end else if (cur_q.cls == i2p_pkg::CLS_OPER) begin
          state_d = i2p_pkg::ST_PUSH;
        end else begin
          state_d = i2p_pkg::ST_FIN;
        end
      end
      i2p_pkg::ST_EVAL: begin
        if (ev_go) begin
          if (cur_q.cls == i2p_pkg::CLS_OPER && !ev_emit) begin
            state_d = i2p_pkg::ST_PUSH;
          end else if (cur_q.cls == i2p_pkg::CLS_CLOSE && top_open) begin
            state_d = i2p_pkg::ST_FIN;
          end else begin
            state_d = i2p_pkg::ST_READ;
          end
        end
      end
      i2p_pkg::ST_PUSH: begin
        state_d = i2p_pkg::ST_FIN;
      end
      i2p_pkg::ST_FIN: begin
        if (fin_go) state_d = i2p_pkg::ST_IDLE;
      end
      default: begin
        state_d = i2p_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath actions per state
  always_comb begin
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    err_d    = err_q;
    pend_v_d = pend_v_q;
    pend_c_d = pend_c_q;
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    emit     = 1'b0;
    emit_c   = i2p_pkg::CH_NUL;
    emit_l   = 1'b0;
    emit_e   = 1'b0;
    unique case (state_q)
      i2p_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          err_d   = 1'b0;
          if (q_item_i.cls == i2p_pkg::CLS_LETTER) begin
            pend_v_d = 1'b1;
            pend_c_d = q_item_i.chr;
          end
        end
      end
      i2p_pkg::ST_READ: begin
        if (stk_empty) begin
          if (cur_q.cls == i2p_pkg::CLS_CLOSE) err_d = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end
      i2p_pkg::ST_EVAL: begin
        if (ev_go) begin
          if (ev_emit) begin
            // Pop and hold as pending; the previous pending one goes out
            pend_v_d = 1'b1;
            pend_c_d = rd_q;
            cnt_d    = cnt_m1;
            if (pend_v_q) begin
              emit   = 1'b1;
              emit_c = pend_c_q;
            end
          end else if (cur_q.cls != i2p_pkg::CLS_OPER) begin
            // Discard an open parenthesis; on flush it is an error
            cnt_d = cnt_m1;
            if (cur_q.cls == i2p_pkg::CLS_FLUSH) err_d = 1'b1;
          end
        end
      end
      i2p_pkg::ST_PUSH: begin
        if (stk_full) begin
          err_d = 1'b1;
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      i2p_pkg::ST_FIN: begin
        if (fin_go) begin
          pend_v_d = 1'b0;
          if (fin_has) begin
            emit   = 1'b1;
            emit_c = pend_v_q ? pend_c_q : i2p_pkg::CH_NUL;
            emit_l = 1'b1;
            emit_e = err_q;
          end
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  assign out_v_d = emit || (out_v_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= i2p_pkg::ST_IDLE;
      cnt_q    <= '0;
      err_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    pend_c_q <= pend_c_d;
    if (emit) begin
      out_c_q <= emit_c;
      out_l_q <= emit_l;
      out_e_q <= emit_e;
    end
  end

  // Stack memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= cur_q.chr;
    if (mem_re) rd_q <= mem[raddr];
  end

  assign out_valid_o  = out_v_q;
  assign out_char_o   = out_c_q;
  assign out_last_o   = out_l_q;
  assign error_flag_o = out_e_q;

endmodule

// ===== hw/rtl/infix_to_postfix_converter_top.sv =====
// Infix-to-postfix converter top level: front end, two-entry queue, stack back end.
// Depends on i2p_pkg, i2p_front, i2p_back and the assertion macro header.
//
//   channel | signals                                      | direction
//   in      | in_valid_i, in_stall_o, req_type_i, in_char_i | into block
//   out     | out_valid_o, out_stall_i, out_char_o,        | out of block
//           | out_last_o, error_flag_o                     |
//
// The back end handles one item at a time: a letter is taken and goes straight to its
// final result, '(' is taken, pushed and finished, and ')', an operator or a flush are
// taken and then examine stack entries one by one (a read of the stack memory port, then
// a decision), followed by the empty-stack check, the push and the final result as needed.
// A two-entry queue lets the front end keep accepting while the back end works.
// Reset clears the queue, stack pointer and output register; no clearing pass.
// A stall on the output holds the back end only when it has a result to hand over.
`include "infix_to_postfix_converter_top_assert.svh"

module infix_to_postfix_converter_top #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       error_flag_o
);

  logic               q_valid;
  logic               q_pop;
  i2p_pkg::i2p_item_t q_item;
  logic               res_mid, res_oper, res_nul;

  // Classification and queue
  i2p_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .in_char_i  (in_char_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // Stack engine and output register
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .out_last_o   (out_last_o),
    .error_flag_o (error_flag_o)
  );

  // Result classification for the checks below
  assign res_mid  = out_valid_o && !out_last_o;
  assign res_oper = (i2p_pkg::prec_of(out_char_o) != 2'd0);
  assign res_nul  = out_valid_o && (out_char_o == i2p_pkg::CH_NUL);

  // Error only marks the final result of an item
  `I2P_ASSERT_NEVER(a_err_on_last, clk_i, rst_ni, res_mid && error_flag_o, "error flag before last")

  // Results before the last one of an item are always popped operators
  `I2P_ASSERT(a_mid_is_oper, clk_i, rst_ni, res_mid |-> res_oper, "non-final result not operator")

  // A null character is only the error marker
  `I2P_ASSERT(a_nul_is_err, clk_i, rst_ni, res_nul |-> (out_last_o && error_flag_o), "null, no error")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for infix_to_postfix_converter_top.
// Needs i2p_pkg and the converter RTL; a built-in shunting-yard predictor
// checks every postfix item against a queue of expected results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2p_pkg::*;

  localparam int unsigned STACK_DEPTH    = 32;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS    = 25;

  // One input item and one postfix result
  typedef struct packed {
    logic       req;
    logic [7:0] chr;
  } infix_item_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       err;
  } postfix_res_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       req_type_i   = REQ_CHAR;
  logic [7:0] in_char_i    = CH_NUL;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic       out_last_o;
  logic       error_flag_o;

  // Stimulus and expected-result stores
  infix_item_t  infix_q[$];
  postfix_res_t postfix_q[$];

  // Predictor state
  logic [7:0]  op_stack [STACK_DEPTH];
  int unsigned stack_cnt = 0;

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 82;
  int unsigned n_queued      = 0;
  int unsigned n_counted     = 0;
  int unsigned n_taken       = 0;
  int unsigned n_flushes     = 0;
  int unsigned n_results     = 0;
  int unsigned n_err_results = 0;
  int unsigned n_errors      = 0;
  int unsigned quiet_cycles  = 0;
  bit          item_taken    = 1'b0;

  infix_to_postfix_converter_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .in_char_i   (in_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .error_flag_o(error_flag_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic int op_rank(logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS: return 1;
      CH_STAR, CH_SLASH: return 2;
      CH_CARET:          return 3;
      default:           return 0;
    endcase
  endfunction

  function automatic bit push_op(logic [7:0] c);
    if (stack_cnt >= STACK_DEPTH) return 1'b0;
    op_stack[stack_cnt] = c;
    stack_cnt++;
    return 1'b1;
  endfunction

  // Shunting-yard step: queue the postfix items that one input item causes
  function automatic void predict_postfix(logic req, logic [7:0] c);
    postfix_res_t res_q[$];
    postfix_res_t tail;
    logic [7:0]   top;
    bit           err;
    bit           found;
    int           rank;
    err   = 1'b0;
    found = 1'b0;
    rank  = op_rank(c);
    if (req == REQ_FLUSH) begin
      // '(' left over at the end is dropped and flagged
      while (stack_cnt > 0) begin
        stack_cnt--;
        top = op_stack[stack_cnt];
        if (top == CH_LPAREN) err = 1'b1;
        else res_q.push_back('{top, 1'b0, 1'b0});
      end
    end else if (is_letter(c)) begin
      res_q.push_back('{c, 1'b0, 1'b0});
    end else if (c == CH_LPAREN) begin
      if (!push_op(c)) err = 1'b1;
    end else if (c == CH_RPAREN) begin
      while (stack_cnt > 0 && !found) begin
        stack_cnt--;
        top = op_stack[stack_cnt];
        if (top == CH_LPAREN) found = 1'b1;
        else res_q.push_back('{top, 1'b0, 1'b0});
      end
      if (!found) err = 1'b1;
    end else if (rank != 0) begin
      while (stack_cnt > 0) begin
        top = op_stack[stack_cnt - 1];
        if (top == CH_LPAREN || op_rank(top) < rank) break;
        stack_cnt--;
        res_q.push_back('{top, 1'b0, 1'b0});
      end
      if (!push_op(c)) err = 1'b1;
    end
    // An error with nothing emitted still produces one marker item
    if (res_q.size() == 0 && err) res_q.push_back('{CH_NUL, 1'b0, 1'b0});
    if (res_q.size() > 0) begin
      tail      = res_q.pop_back();
      tail.last = 1'b1;
      tail.err  = err;
      res_q.push_back(tail);
    end
    foreach (res_q[i]) postfix_q.push_back(res_q[i]);
  endfunction

  // Stimulus helpers
  task automatic add_item(logic req, logic [7:0] c);
    infix_q.push_back('{req, c});
    n_queued++;
    if (req == REQ_FLUSH || is_letter(c) || op_rank(c) != 0 ||
        c == CH_LPAREN || c == CH_RPAREN) n_counted++;
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return CH_LO_A + 8'($urandom_range(25));
    return CH_UP_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] rand_token();
    case ($urandom_range(8))
      0, 1:    return rand_letter();
      7:       return CH_LPAREN;
      8:       return CH_RPAREN;
      default: return rand_op();
    endcase
  endfunction

  // Well-formed expression with random nesting
  task automatic gen_expr(int depth);
    int n_terms;
    n_terms = $urandom_range(1, 4);
    for (int k = 0; k < n_terms; k++) begin
      if (k > 0) add_item(REQ_CHAR, rand_op());
      if (depth < 3 && $urandom_range(3) == 0) begin
        add_item(REQ_CHAR, CH_LPAREN);
        gen_expr(depth + 1);
        add_item(REQ_CHAR, CH_RPAREN);
      end else begin
        add_item(REQ_CHAR, rand_letter());
      end
    end
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || postfix_q.size() != 0) @(negedge clk_i);
  endtask

  // Driver: new item only once the previous one went through
  always @(negedge clk_i) begin
    infix_item_t nxt;
    if (!in_valid_i || item_taken) begin
      if (infix_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = infix_q.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= nxt.req;
        in_char_i  <= nxt.chr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: predict on input handshake, check on output handshake
  always @(posedge clk_i) begin
    postfix_res_t want;
    if (rst_ni) begin
      item_taken = in_valid_i && !in_stall_o;
      if (item_taken) begin
        predict_postfix(req_type_i, in_char_i);
        n_taken++;
        if (req_type_i == REQ_FLUSH) n_flushes++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (error_flag_o) n_err_results++;
        if (postfix_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected item char=%h last=%b err=%b",
                   $time, out_char_o, out_last_o, error_flag_o);
        end else begin
          want = postfix_q.pop_front();
          if (out_char_o !== want.chr || out_last_o !== want.last ||
              error_flag_o !== want.err) begin
            n_errors++;
            $display("%0t: mismatch expected char=%h last=%b err=%b, got char=%h last=%b err=%b",
                     $time, want.chr, want.last, want.err,
                     out_char_o, out_last_o, error_flag_o);
          end
        end
      end
      // Watchdog on handshake activity
      if (item_taken || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int unsigned goal;
    int          kind;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty flush, letter range edges, ignored characters
    add_item(REQ_FLUSH, 8'hFF);
    add_item(REQ_CHAR, CH_LO_A);
    add_item(REQ_CHAR, CH_LO_Z);
    add_item(REQ_CHAR, CH_UP_A);
    add_item(REQ_CHAR, CH_UP_Z);
    add_item(REQ_CHAR, CH_UP_A - 8'd1);
    add_item(REQ_CHAR, CH_UP_Z + 8'd1);
    add_item(REQ_CHAR, CH_LO_A - 8'd1);
    add_item(REQ_CHAR, CH_LO_Z + 8'd1);
    add_item(REQ_CHAR, CH_NUL);
    add_item(REQ_CHAR, 8'hFF);
    // Closing parenthesis on an empty stack
    add_item(REQ_CHAR, CH_RPAREN);
    // (a+b*c^d-e/f) covers every operator and precedence level
    add_item(REQ_CHAR, CH_LPAREN);
    add_item(REQ_CHAR, CH_LO_A);
    add_item(REQ_CHAR, CH_PLUS);
    add_item(REQ_CHAR, CH_LO_A + 8'd1);
    add_item(REQ_CHAR, CH_STAR);
    add_item(REQ_CHAR, CH_LO_A + 8'd2);
    add_item(REQ_CHAR, CH_CARET);
    add_item(REQ_CHAR, CH_LO_A + 8'd3);
    add_item(REQ_CHAR, CH_MINUS);
    add_item(REQ_CHAR, CH_LO_A + 8'd4);
    add_item(REQ_CHAR, CH_SLASH);
    add_item(REQ_CHAR, CH_LO_A + 8'd5);
    add_item(REQ_CHAR, CH_RPAREN);
    // Open parenthesis left at flush
    add_item(REQ_CHAR, CH_LPAREN);
    add_item(REQ_CHAR, CH_PLUS);
    add_item(REQ_FLUSH, CH_NUL);
    wait_drained();

    // Random phases with different idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = n_counted + PHASE_ITEMS;
      // Overflow: fill the stack with '(' then push once more
      if (phase == 1) begin
        repeat (STACK_DEPTH + 1) add_item(REQ_CHAR, CH_LPAREN);
        add_item(REQ_CHAR, rand_letter());
        add_item(REQ_CHAR, rand_op());
        add_item(REQ_FLUSH, 8'($urandom_range(255)));
      end
      while (n_counted < goal) begin
        kind = $urandom_range(9);
        if (kind < 6) begin
          gen_expr(0);
          add_item(REQ_FLUSH, 8'($urandom_range(255)));
        end else if (kind == 6) begin
          repeat ($urandom_range(1, 4)) add_item(REQ_CHAR, 8'($urandom_range(255)));
        end else begin
          // Broken sequence of tokens, flushed only sometimes
          repeat ($urandom_range(2, 8)) add_item(REQ_CHAR, rand_token());
          if ($urandom_range(1)) add_item(REQ_FLUSH, 8'($urandom_range(255)));
        end
      end
      wait_drained();
    end

    add_item(REQ_FLUSH, CH_NUL);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (postfix_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected items never arrived", $time, postfix_q.size());
    end

    $display("Sent %0d infix items (%0d flushes); checked %0d postfix items, %0d flagged",
             n_taken, n_flushes, n_results, n_err_results);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_front.sv
hw/rtl/i2p_back.sv
hw/rtl/infix_to_postfix_converter_top.sv
tb/tb.sv
